// ===== hdl/mpd_pkg.sv =====
// ----------------------------------------------------------------------------
// mpd_pkg
// Shared widths, register indexes, reset values and the per-channel maximum
// used by the max-pooling downscaler.
// ----------------------------------------------------------------------------
package mpd_pkg;

    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int SCALE_W     = 8;
    localparam int CHAN_W      = 8;
    localparam int PIX_W       = 3 * CHAN_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_FACTOR  = 2'd2;

    localparam logic [CFG_DATA_W-1:0] RESET_SOURCE_WIDTH  = 13'd640;
    localparam logic [CFG_DATA_W-1:0] RESET_SOURCE_HEIGHT = 13'd480;
    localparam logic [SCALE_W-1:0]    RESET_SCALE_FACTOR  = 8'd2;
    localparam logic [SCALE_W-1:0]    MIN_SCALE_FACTOR    = 8'd2;

    localparam int DEF_MAX_OUTPUT_WIDTH = 2048;
    localparam int DEF_MAX_SOURCE_WIDTH = 4096;

    // Channel-wise maximum of two packed {red, green, blue} pixels.
    function automatic logic [PIX_W-1:0] chan_max(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        logic [PIX_W-1:0]  res;
        logic [CHAN_W-1:0] ca;
        logic [CHAN_W-1:0] cb;
        res = '0;
        for (int c = 0; c < 3; c++) begin
            ca = a[c*CHAN_W +: CHAN_W];
            cb = b[c*CHAN_W +: CHAN_W];
            res[c*CHAN_W +: CHAN_W] = (ca > cb) ? ca : cb;
        end
        return res;
    endfunction

endpackage

// ===== hdl/mpd_ram.sv =====
// ----------------------------------------------------------------------------
// mpd_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module mpd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/mpd_dims.sv =====
// ----------------------------------------------------------------------------
// mpd_dims
// Derives the working frame geometry from the configuration registers:
// clamped width, height and scale, output width and the pooled area.
// A shared-step restoring divider produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mpd_dims #(
    parameter int MAX_SOURCE_WIDTH = mpd_pkg::DEF_MAX_SOURCE_WIDTH,
    parameter int MAX_OUTPUT_WIDTH = mpd_pkg::DEF_MAX_OUTPUT_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [mpd_pkg::CFG_DATA_W-1:0]        i_cfg_width,
    input  logic [mpd_pkg::CFG_DATA_W-1:0]        i_cfg_height,
    input  logic [mpd_pkg::SCALE_W-1:0]           i_cfg_scale,
    output logic                                  o_busy,
    output logic [$clog2(MAX_SOURCE_WIDTH+1)-1:0] o_width,
    output logic [$clog2(MAX_SOURCE_WIDTH+1)-1:0] o_height,
    output logic [mpd_pkg::SCALE_W-1:0]           o_scale,
    output logic [$clog2(MAX_OUTPUT_WIDTH+1)-1:0] o_out_width,
    output logic [$clog2(MAX_SOURCE_WIDTH+1)-1:0] o_pool_width,
    output logic [$clog2(MAX_SOURCE_WIDTH+1)-1:0] o_pool_height
);

    localparam int WW   = $clog2(MAX_SOURCE_WIDTH + 1);
    localparam int OCW  = $clog2(MAX_OUTPUT_WIDTH + 1);
    localparam int SW   = mpd_pkg::SCALE_W;
    localparam int CNTW = $clog2(WW + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;

    logic [1:0]      r_state;
    logic [CNTW-1:0] r_cnt;
    logic [WW-1:0]   r_qw;
    logic [WW-1:0]   r_qh;
    logic [SW-1:0]   r_rw;
    logic [SW-1:0]   r_rh;
    logic [WW-1:0]   r_width;
    logic [WW-1:0]   r_height;
    logic [SW-1:0]   r_scale;
    logic [OCW-1:0]  r_out_width;
    logic [WW-1:0]   r_pool_width;
    logic [WW-1:0]   r_pool_height;

    logic [WW-1:0]     n_width;
    logic [WW-1:0]     n_height;
    logic [SW-1:0]     n_scale;
    logic [SW:0]       trial_w;
    logic [SW:0]       trial_h;
    logic              ge_w;
    logic              ge_h;
    logic [OCW-1:0]    n_out_width;
    logic [OCW+SW-1:0] prod_w;
    logic [WW+SW-1:0]  prod_h;

    // Zero width or height reads as one, oversize reads as the maximum.
    always_comb begin
        if (i_cfg_width == '0) begin
            n_width = WW'(1);
        end else if (32'(i_cfg_width) > 32'(MAX_SOURCE_WIDTH)) begin
            n_width = WW'(MAX_SOURCE_WIDTH);
        end else begin
            n_width = WW'(i_cfg_width);
        end
        if (i_cfg_height == '0) begin
            n_height = WW'(1);
        end else if (32'(i_cfg_height) > 32'(MAX_SOURCE_WIDTH)) begin
            n_height = WW'(MAX_SOURCE_WIDTH);
        end else begin
            n_height = WW'(i_cfg_height);
        end
        n_scale = (i_cfg_scale < mpd_pkg::MIN_SCALE_FACTOR) ? mpd_pkg::MIN_SCALE_FACTOR
                                                            : i_cfg_scale;
    end

    always_comb begin
        trial_w = {r_rw, r_qw[WW-1]};
        trial_h = {r_rh, r_qh[WW-1]};
        ge_w    = trial_w >= {1'b0, r_scale};
        ge_h    = trial_h >= {1'b0, r_scale};
        if (32'(r_qw) > 32'(MAX_OUTPUT_WIDTH)) begin
            n_out_width = OCW'(MAX_OUTPUT_WIDTH);
        end else begin
            n_out_width = OCW'(r_qw);
        end
        prod_w = (OCW+SW)'(n_out_width) * (OCW+SW)'(r_scale);
        prod_h = (WW+SW)'(r_qh) * (WW+SW)'(r_scale);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else if (i_start) begin
            r_state <= ST_DIV;
        end else begin
            unique case (r_state)
                ST_IDLE: r_state <= ST_IDLE;
                ST_DIV:  r_state <= (r_cnt == CNTW'(1)) ? ST_MUL : ST_DIV;
                ST_MUL:  r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_width  <= n_width;
            r_height <= n_height;
            r_scale  <= n_scale;
            r_qw     <= n_width;
            r_qh     <= n_height;
            r_rw     <= '0;
            r_rh     <= '0;
            r_cnt    <= CNTW'(WW);
        end else if (r_state == ST_DIV) begin
            r_rw  <= ge_w ? SW'(trial_w - {1'b0, r_scale}) : trial_w[SW-1:0];
            r_rh  <= ge_h ? SW'(trial_h - {1'b0, r_scale}) : trial_h[SW-1:0];
            r_qw  <= {r_qw[WW-2:0], ge_w};
            r_qh  <= {r_qh[WW-2:0], ge_h};
            r_cnt <= r_cnt - CNTW'(1);
        end else if (r_state == ST_MUL) begin
            r_out_width   <= n_out_width;
            r_pool_width  <= WW'(prod_w);
            r_pool_height <= WW'(prod_h);
        end
    end

    assign o_busy        = i_start || (r_state != ST_IDLE);
    assign o_width       = r_width;
    assign o_height      = r_height;
    assign o_scale       = r_scale;
    assign o_out_width   = r_out_width;
    assign o_pool_width  = r_pool_width;
    assign o_pool_height = r_pool_height;

endmodule

// ===== hdl/max_pool_downscale.sv =====
// ----------------------------------------------------------------------------
// max_pool_downscale
// A result passes through the merge stage and the result register after the
// request that completes its block is accepted. Throughput: one pixel per
// cycle while the output is not stalled and no geometry is being derived, set
// by the single read-modify-write of the line of bins per block column.
// Reset is synchronous and active low. After reset, and after every register
// write, input ready stays low while the divider derives the output geometry.
// ----------------------------------------------------------------------------
module max_pool_downscale #(
    parameter int MAX_OUTPUT_WIDTH = mpd_pkg::DEF_MAX_OUTPUT_WIDTH,
    parameter int MAX_SOURCE_WIDTH = mpd_pkg::DEF_MAX_SOURCE_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port.
    input  logic                               i_cfg_we,
    input  logic [mpd_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [mpd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Source pixel channel.
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [mpd_pkg::CHAN_W-1:0]         i_pixel_blue,
    input  logic [mpd_pkg::CHAN_W-1:0]         i_pixel_green,
    input  logic [mpd_pkg::CHAN_W-1:0]         i_pixel_red,
    input  logic                               i_frame_start,
    // Pooled pixel channel.
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [mpd_pkg::CHAN_W-1:0]         o_max_blue,
    output logic [mpd_pkg::CHAN_W-1:0]         o_max_green,
    output logic [mpd_pkg::CHAN_W-1:0]         o_max_red,
    output logic                               o_row_end,
    output logic                               o_frame_end
);

    localparam int WW    = $clog2(MAX_SOURCE_WIDTH + 1);   // dimension width
    localparam int CPW   = $clog2(MAX_SOURCE_WIDTH);       // source position
    localparam int OCW   = $clog2(MAX_OUTPUT_WIDTH + 1);   // output column
    localparam int BAW   = $clog2(MAX_OUTPUT_WIDTH);       // bin address
    localparam int SW    = mpd_pkg::SCALE_W;
    localparam int CW    = mpd_pkg::CHAN_W;
    localparam int PW    = mpd_pkg::PIX_W;

    // ------------------------------------------------------------------
    // Configuration registers. A write triggers a recompute of the
    // derived geometry, which holds off new requests until it is done.
    // ------------------------------------------------------------------
    logic [mpd_pkg::CFG_DATA_W-1:0] r_cfg_width;
    logic [mpd_pkg::CFG_DATA_W-1:0] r_cfg_height;
    logic [SW-1:0]                  r_cfg_scale;
    logic                           r_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= mpd_pkg::RESET_SOURCE_WIDTH;
            r_cfg_height <= mpd_pkg::RESET_SOURCE_HEIGHT;
            r_cfg_scale  <= mpd_pkg::RESET_SCALE_FACTOR;
            r_start      <= 1'b1;
        end else begin
            r_start <= i_cfg_we;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    mpd_pkg::CFG_SOURCE_WIDTH:  r_cfg_width  <= i_cfg_data;
                    mpd_pkg::CFG_SOURCE_HEIGHT: r_cfg_height <= i_cfg_data;
                    mpd_pkg::CFG_SCALE_FACTOR:  r_cfg_scale  <= i_cfg_data[SW-1:0];
                    default: ;
                endcase
            end
        end
    end

    logic           dims_busy;
    logic [WW-1:0]  width;
    logic [WW-1:0]  height;
    logic [SW-1:0]  scale;
    logic [OCW-1:0] out_width;
    logic [WW-1:0]  pool_width;
    logic [WW-1:0]  pool_height;

    mpd_dims #(
        .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH),
        .MAX_OUTPUT_WIDTH (MAX_OUTPUT_WIDTH)
    ) u_dims (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (r_start),
        .i_cfg_width   (r_cfg_width),
        .i_cfg_height  (r_cfg_height),
        .i_cfg_scale   (r_cfg_scale),
        .o_busy        (dims_busy),
        .o_width       (width),
        .o_height      (height),
        .o_scale       (scale),
        .o_out_width   (out_width),
        .o_pool_width  (pool_width),
        .o_pool_height (pool_height)
    );

    // ------------------------------------------------------------------
    // Pipeline control. The whole pipe advances together whenever the
    // output register is empty or being drained.
    // ------------------------------------------------------------------
    logic r_out_valid;
    logic advance;
    logic accept;

    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = advance && !dims_busy;
    assign accept     = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // Accept stage: position tracking and the running maximum within one
    // block row. A frame-start request sees all counters as cleared.
    // ------------------------------------------------------------------
    logic [CPW-1:0] r_col;
    logic [CPW-1:0] r_row;
    logic [SW-1:0]  r_ox;
    logic [SW-1:0]  r_oy;
    logic [OCW-1:0] r_ocol;
    logic [PW-1:0]  r_acc;

    logic [CPW-1:0] eff_col;
    logic [CPW-1:0] eff_row;
    logic [SW-1:0]  eff_ox;
    logic [SW-1:0]  eff_oy;
    logic [OCW-1:0] eff_ocol;
    logic [PW-1:0]  eff_acc;

    logic [PW-1:0]  pix;
    logic           in_pool;
    logic           block_done;
    logic           block_last_row;
    logic           row_end;
    logic           frame_end;
    logic [PW-1:0]  acc_new;
    logic [BAW-1:0] bin_addr;

    logic [CPW-1:0] n_col;
    logic [CPW-1:0] n_row;
    logic [SW-1:0]  n_ox;
    logic [SW-1:0]  n_oy;
    logic [OCW-1:0] n_ocol;
    logic [PW-1:0]  n_acc;

    always_comb begin
        eff_col  = i_frame_start ? '0 : r_col;
        eff_row  = i_frame_start ? '0 : r_row;
        eff_ox   = i_frame_start ? '0 : r_ox;
        eff_oy   = i_frame_start ? '0 : r_oy;
        eff_ocol = i_frame_start ? '0 : r_ocol;
        eff_acc  = i_frame_start ? '0 : r_acc;

        pix = {i_pixel_red, i_pixel_green, i_pixel_blue};

        // Pixels outside the pooled area (leftover columns and rows) have
        // no effect apart from moving the position counters.
        in_pool = (WW'(eff_col) < pool_width) && (WW'(eff_row) < pool_height) &&
                  (eff_ocol < out_width) && (eff_ox < scale) && (eff_oy < scale);

        acc_new        = (eff_ox == '0) ? pix : mpd_pkg::chan_max(eff_acc, pix);
        block_done     = in_pool && (eff_ox == scale - SW'(1));
        block_last_row = (eff_oy == scale - SW'(1));
        row_end        = (eff_ocol + OCW'(1) == out_width);
        frame_end      = row_end && (WW'(eff_row) + WW'(1) == pool_height);
        bin_addr       = eff_ocol[BAW-1:0];

        n_acc  = in_pool ? acc_new : eff_acc;
        n_ocol = block_done ? eff_ocol + OCW'(1) : eff_ocol;
        n_col  = eff_col;
        n_row  = eff_row;
        n_ox   = eff_ox;
        n_oy   = eff_oy;

        if (WW'(eff_col) + WW'(1) >= width) begin
            // End of a source line.
            n_col  = '0;
            n_ox   = '0;
            n_ocol = '0;
            if (WW'(eff_row) < pool_height) begin
                n_oy = ((SW+1)'(eff_oy) + (SW+1)'(1) >= (SW+1)'(scale)) ? '0
                                                                         : eff_oy + SW'(1);
            end
            if (WW'(eff_row) + WW'(1) >= height) begin
                n_row = '0;
                n_oy  = '0;
            end else begin
                n_row = eff_row + CPW'(1);
            end
        end else begin
            n_col = eff_col + CPW'(1);
            n_ox  = ((SW+1)'(eff_ox) + (SW+1)'(1) >= (SW+1)'(scale)) ? '0
                                                                     : eff_ox + SW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_ox   <= '0;
            r_oy   <= '0;
            r_ocol <= '0;
            r_acc  <= '0;
        end else if (accept) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_ox   <= n_ox;
            r_oy   <= n_oy;
            r_ocol <= n_ocol;
            r_acc  <= n_acc;
        end
    end

    // ------------------------------------------------------------------
    // Merge stage: the bin of the block column is read on accept and
    // merged with the block-row maximum from the registered read data. When
    // the merge stage writes the same bin that is read in the same cycle,
    // the new value is forwarded around the RAM.
    // ------------------------------------------------------------------
    logic           r_s1_valid;
    logic           r_s1_write;
    logic           r_s1_emit;
    logic           r_s1_first_row;
    logic           r_s1_row_end;
    logic           r_s1_frame_end;
    logic [BAW-1:0] r_s1_addr;
    logic [PW-1:0]  r_s1_acc;
    logic           r_s1_fwd;
    logic [PW-1:0]  r_s1_fwd_data;

    logic [PW-1:0]  ram_rdata;
    logic [PW-1:0]  bin_value;
    logic [PW-1:0]  merged;
    logic           bin_we;

    assign bin_value = r_s1_fwd ? r_s1_fwd_data : ram_rdata;
    assign merged    = r_s1_first_row ? r_s1_acc : mpd_pkg::chan_max(bin_value, r_s1_acc);
    assign bin_we    = advance && r_s1_valid && r_s1_write;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_write     <= block_done;
            r_s1_emit      <= block_last_row;
            r_s1_first_row <= (eff_oy == '0);
            r_s1_row_end   <= row_end;
            r_s1_frame_end <= frame_end;
            r_s1_addr      <= bin_addr;
            r_s1_acc       <= acc_new;
            r_s1_fwd       <= bin_we && (r_s1_addr == bin_addr);
            r_s1_fwd_data  <= merged;
        end
    end

    mpd_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_OUTPUT_WIDTH)
    ) u_bin_ram (
        .i_clk   (i_clk),
        .i_we    (bin_we),
        .i_waddr (r_s1_addr),
        .i_wdata (merged),
        .i_re    (accept),
        .i_raddr (bin_addr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Result register. It parts the output handshake from the pipe, so a
    // new request is taken while a finished pixel is being drained.
    // ------------------------------------------------------------------
    logic [PW-1:0] r_out_pix;
    logic          r_out_row_end;
    logic          r_out_frame_end;
    logic          s1_result;

    assign s1_result = r_s1_valid && r_s1_write && r_s1_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= s1_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && s1_result) begin
            r_out_pix       <= merged;
            r_out_row_end   <= r_s1_row_end;
            r_out_frame_end <= r_s1_frame_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_max_blue  = r_out_pix[0 +: CW];
    assign o_max_green = r_out_pix[CW +: CW];
    assign o_max_red   = r_out_pix[2*CW +: CW];
    assign o_row_end   = r_out_row_end;
    assign o_frame_end = r_out_frame_end;

endmodule

// ===== hdl/mpd_checker.sv =====
// ----------------------------------------------------------------------------
// mpd_checker
// Port-level checks of the max-pooling downscaler, bound to its top level.
// ----------------------------------------------------------------------------
module mpd_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_cfg_we,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic                            o_row_end,
    input logic                            o_frame_end,
    input logic [mpd_pkg::CHAN_W-1:0]      o_max_blue
);

    // A pending result is held until it is taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_max_blue))
        else $error("pooled pixel dropped or changed while stalled");

    // The last pixel of a frame is also the last of its row.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_end |-> o_row_end)
        else $error("frame end without row end");

    // A register write holds off requests while the geometry is recomputed.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !o_in_ready)
        else $error("request accepted right after a register write");

    // Reset leaves no result and holds off requests.
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("block not quiet after reset");

endmodule

bind max_pool_downscale mpd_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_row_end   (o_row_end),
    .o_frame_end (o_frame_end),
    .o_max_blue  (o_max_blue)
);

// ===== verif/max_pool_downscale_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_pool_downscale_tb
// Self-checking bench for the max-pooling downscaler. Raster pixel streams are
// queued by a stimulus process and fed by a clocked driver. Every accepted
// pixel updates a behavioral pooling predictor, which queues the pooled pixel
// it completes, if any. A clocked monitor checks each pooled pixel, field by
// field, against the oldest queued one. The run covers directed geometries,
// the reset geometry and random frames, with random idling on both sides.
// ----------------------------------------------------------------------------
module max_pool_downscale_tb;

    localparam int MAX_OUT_W      = mpd_pkg::DEF_MAX_OUTPUT_WIDTH;
    localparam int MAX_SRC_W      = mpd_pkg::DEF_MAX_SOURCE_WIDTH;
    // This margin covers the path through the merge stage and the result register with room to spare.
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int MAX_PRINTS     = 60;

    typedef struct packed {
        logic [mpd_pkg::CHAN_W-1:0] red;
        logic [mpd_pkg::CHAN_W-1:0] green;
        logic [mpd_pkg::CHAN_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        t_rgb color;
        logic frame_start;
    } t_pixel;

    typedef struct packed {
        t_rgb color;
        logic row_end;
        logic frame_end;
    } t_pooled;

    // Clock, reset and DUT ports. Every input starts at a known value.
    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            i_cfg_we      = 1'b0;
    logic [mpd_pkg::CFG_INDEX_W-1:0] i_cfg_index   = mpd_pkg::CFG_SOURCE_WIDTH;
    logic [mpd_pkg::CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                            i_in_valid    = 1'b0;
    logic                            o_in_ready;
    logic [mpd_pkg::CHAN_W-1:0]      i_pixel_blue  = '0;
    logic [mpd_pkg::CHAN_W-1:0]      i_pixel_green = '0;
    logic [mpd_pkg::CHAN_W-1:0]      i_pixel_red   = '0;
    logic                            i_frame_start = 1'b0;
    logic                            o_out_valid;
    logic                            i_out_ready   = 1'b0;
    logic [mpd_pkg::CHAN_W-1:0]      o_max_blue;
    logic [mpd_pkg::CHAN_W-1:0]      o_max_green;
    logic [mpd_pkg::CHAN_W-1:0]      o_max_red;
    logic                            o_row_end;
    logic                            o_frame_end;

    // Pixels waiting to be offered, and pooled pixels waiting to be seen.
    t_pixel  pixel_queue[$];
    t_pooled pooled_expected[$];

    // Idle percentages for the sender and the receiver.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // Receiver hold-off: the stimulus process bumps the request count and the
    // hold-off process answers with a long run of ready low.
    int          hold_requests = 0;
    int          hold_served   = 0;
    int unsigned hold_left     = 0;

    int          error_count   = 0;
    int          result_index  = 0;
    int          random_pixels = 0;
    int          cycle_count   = 0;

    // Shadow of the configuration registers.
    logic [mpd_pkg::CFG_DATA_W-1:0] cfg_width  = mpd_pkg::RESET_SOURCE_WIDTH;
    logic [mpd_pkg::CFG_DATA_W-1:0] cfg_height = mpd_pkg::RESET_SOURCE_HEIGHT;
    logic [mpd_pkg::SCALE_W-1:0]    cfg_scale  = mpd_pkg::RESET_SCALE_FACTOR;

    // Predictor state: one running-max bin per output column, the running max
    // along the current block row, and the raster and block positions.
    t_rgb        pool_bins [MAX_OUT_W];
    t_rgb        row_max   = '0;
    int unsigned src_col   = 0;
    int unsigned src_row   = 0;
    int unsigned blk_x     = 0;
    int unsigned blk_y     = 0;
    int unsigned bin_col   = 0;

    // Scratch variables of the driver and the monitor.
    t_pixel  next_pixel;
    t_pixel  taken_pixel;
    t_pooled predicted;
    t_pooled want;
    bit      completes_block;

    max_pool_downscale u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_pixel_blue  (i_pixel_blue),
        .i_pixel_green (i_pixel_green),
        .i_pixel_red   (i_pixel_red),
        .i_frame_start (i_frame_start),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_max_blue    (o_max_blue),
        .o_max_green   (o_max_green),
        .o_max_red     (o_max_red),
        .o_row_end     (o_row_end),
        .o_frame_end   (o_frame_end)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Pooling predictor
    // ------------------------------------------------------------------------

    // Per-channel maximum of two pixels.
    function automatic t_rgb brighter(input t_rgb a, input t_rgb b);
        t_rgb m;
        m.red   = (a.red   > b.red)   ? a.red   : b.red;
        m.green = (a.green > b.green) ? a.green : b.green;
        m.blue  = (a.blue  > b.blue)  ? a.blue  : b.blue;
        return m;
    endfunction

    // A zero dimension counts as one; anything above the source limit is
    // clipped to the limit.
    function automatic int unsigned clip_dim(input logic [mpd_pkg::CFG_DATA_W-1:0] d);
        if (d == 0) begin
            return 1;
        end
        if (32'(d) > MAX_SRC_W) begin
            return MAX_SRC_W;
        end
        return 32'(d);
    endfunction

    // Advances the predictor by one source pixel. Returns 1 when the pixel is
    // the bottom-right corner of a pooled block, with the pooled pixel in res.
    function automatic bit pool_pixel(input t_pixel px, output t_pooled res);
        int unsigned scale;
        int unsigned w;
        int unsigned h;
        int unsigned ow;
        int unsigned oh;
        int unsigned col;
        t_rgb        merged;
        bit          done;
        done  = 1'b0;
        res   = '0;
        scale = (cfg_scale < mpd_pkg::MIN_SCALE_FACTOR) ? 32'(mpd_pkg::MIN_SCALE_FACTOR)
                                                        : 32'(cfg_scale);
        w     = clip_dim(cfg_width);
        h     = clip_dim(cfg_height);
        ow    = w / scale;
        oh    = h / scale;
        if (ow > MAX_OUT_W) begin
            ow = MAX_OUT_W;
        end

        // A frame start clears every position before the pixel is used.
        if (px.frame_start) begin
            row_max = '0;
            src_col = 0;
            src_row = 0;
            blk_x   = 0;
            blk_y   = 0;
            bin_col = 0;
        end

        // Pixels in the leftover columns and rows fall outside every block.
        if (src_col < ow * scale && src_row < oh * scale && bin_col < ow &&
            blk_x < scale && blk_y < scale) begin
            row_max = (blk_x == 0) ? px.color : brighter(row_max, px.color);
            if (blk_x == scale - 1) begin
                col    = bin_col;
                merged = (blk_y == 0) ? row_max : brighter(pool_bins[col], row_max);
                pool_bins[col] = merged;
                if (blk_y == scale - 1) begin
                    res.color     = merged;
                    res.row_end   = (col + 1 == ow);
                    res.frame_end = res.row_end && (src_row + 1 == oh * scale);
                    done          = 1'b1;
                end
                bin_col = col + 1;
            end
        end

        // Raster advance; the bounds are compared with >= so that positions
        // wrap cleanly even when the geometry shrinks under them.
        if (src_col + 1 >= w) begin
            src_col = 0;
            blk_x   = 0;
            bin_col = 0;
            if (src_row < oh * scale) begin
                blk_y = (blk_y + 1 >= scale) ? 0 : blk_y + 1;
            end
            if (src_row + 1 >= h) begin
                src_row = 0;
                blk_y   = 0;
            end else begin
                src_row++;
            end
        end else begin
            src_col++;
            blk_x = (blk_x + 1 >= scale) ? 0 : blk_x + 1;
        end
        return done;
    endfunction

    // ------------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers queued pixels, and feeds each accepted request to the
    // predictor. Valid and payload only change when nothing is on offer or
    // the offered request has just been taken.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                taken_pixel     = {i_pixel_red, i_pixel_green, i_pixel_blue, i_frame_start};
                completes_block = pool_pixel(taken_pixel, predicted);
                if (completes_block) begin
                    pooled_expected.push_back(predicted);
                end
            end
            if (!i_in_valid || o_in_ready) begin
                if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_pixel     = pixel_queue.pop_front();
                    i_in_valid    <= 1'b1;
                    i_pixel_blue  <= next_pixel.color.blue;
                    i_pixel_green <= next_pixel.color.green;
                    i_pixel_red   <= next_pixel.color.red;
                    i_frame_start <= next_pixel.frame_start;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks every accepted pooled pixel against the oldest one the
    // predictor produced, then picks the ready level for the next cycle.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pooled_expected.size() == 0) begin
                    report_mismatch($sformatf("pooled pixel %0d arrived with none pending",
                                              result_index));
                end else begin
                    want = pooled_expected.pop_front();
                    if (o_max_blue !== want.color.blue) begin
                        report_mismatch($sformatf("pixel %0d blue: got %0d, want %0d",
                                                  result_index, o_max_blue, want.color.blue));
                    end
                    if (o_max_green !== want.color.green) begin
                        report_mismatch($sformatf("pixel %0d green: got %0d, want %0d",
                                                  result_index, o_max_green, want.color.green));
                    end
                    if (o_max_red !== want.color.red) begin
                        report_mismatch($sformatf("pixel %0d red: got %0d, want %0d",
                                                  result_index, o_max_red, want.color.red));
                    end
                    if (o_row_end !== want.row_end) begin
                        report_mismatch($sformatf("pixel %0d row_end: got %0b, want %0b",
                                                  result_index, o_row_end, want.row_end));
                    end
                    if (o_frame_end !== want.frame_end) begin
                        report_mismatch($sformatf("pixel %0d frame_end: got %0b, want %0b",
                                                  result_index, o_frame_end, want.frame_end));
                    end
                end
                result_index++;
            end
            i_out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Receiver hold-off counter. While it runs, ready stays low and the block
    // has to back up into its input.
    always @(posedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Watchdog on the total run length.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Waits until every queued pixel is taken and every pooled pixel seen,
    // then lets the pipeline run dry before anything else happens.
    task automatic drain_block();
        do begin
            @(negedge i_clk);
        end while (pixel_queue.size() != 0 || i_in_valid || pooled_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Writes one register and mirrors it in the predictor's shadow copy. Only
    // called while the block is drained.
    task automatic write_reg(input logic [mpd_pkg::CFG_INDEX_W-1:0] idx,
                             input int unsigned val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[mpd_pkg::CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            mpd_pkg::CFG_SOURCE_WIDTH:  cfg_width  = val[mpd_pkg::CFG_DATA_W-1:0];
            mpd_pkg::CFG_SOURCE_HEIGHT: cfg_height = val[mpd_pkg::CFG_DATA_W-1:0];
            mpd_pkg::CFG_SCALE_FACTOR:  cfg_scale  = val[mpd_pkg::SCALE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h,
                                input int unsigned s);
        drain_block();
        write_reg(mpd_pkg::CFG_SOURCE_WIDTH, w);
        write_reg(mpd_pkg::CFG_SOURCE_HEIGHT, h);
        write_reg(mpd_pkg::CFG_SCALE_FACTOR, s);
    endtask

    // Queues n random pixels. The first carries the given frame-start flag;
    // with a nonzero noise_den, later ones carry a stray flag one time in
    // noise_den.
    task automatic queue_frame(input int unsigned n, input bit first_flag,
                               input int unsigned noise_den);
        t_pixel px;
        for (int unsigned k = 0; k < n; k++) begin
            px.color       = mpd_pkg::PIX_W'($urandom);
            px.frame_start = (k == 0) ? first_flag :
                             (noise_den != 0 && $urandom_range(noise_den - 1) == 0);
            pixel_queue.push_back(px);
            random_pixels++;
        end
    endtask

    // One random geometry with a few frames. Most frames are whole and start
    // with the flag; the rest lean on the raster wrap, stop early, or carry
    // stray frame starts. The first frame is always flagged, so every bin is
    // written under the new geometry before it is read back.
    task automatic random_phase();
        int unsigned w;
        int unsigned h;
        int unsigned s;
        int unsigned area;
        int unsigned frames;
        int unsigned kind;
        w = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 16);
        h = $urandom_range(0, 8);
        s = $urandom_range(0, 7);
        set_geometry(w, h, s);
        area   = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
        frames = $urandom_range(1, 3);
        for (int unsigned f = 0; f < frames; f++) begin
            kind = $urandom_range(9);
            if (f == 0 || kind < 7) begin
                queue_frame(area, 1'b1, 0);
            end else if (kind == 7) begin
                queue_frame(area, 1'b0, 0);
            end else if (kind == 8) begin
                queue_frame($urandom_range(1, area), 1'b1, 0);
            end else begin
                queue_frame($urandom_range(1, 2 * area), 1'b1, 8);
            end
        end
    endtask

    task automatic random_phases_until(input int target);
        while (random_pixels < target) begin
            random_phase();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_rgb c;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // First stretch: sender idles lightly, receiver heavily.
        send_idle_pct = 24;
        recv_idle_pct = 67;

        // Reset geometry, 640 wide with scale two. The sender stops after the
        // first source row until the block is drained, then the receiver
        // holds off while the first blocks of the second row complete.
        queue_frame(640, 1'b1, 0);
        drain_block();
        hold_requests++;
        queue_frame(4, 1'b0, 0);

        // 4x4 at scale two with channel extremes and toggling bit patterns,
        // then a frame that starts through the raster wrap alone, then a
        // frame start in the middle of that frame.
        set_geometry(4, 4, 2);
        for (int k = 0; k < 16; k++) begin
            c.blue  = 8'(k * 17);
            c.green = 8'(255 - k * 17);
            c.red   = k[0] ? 8'hAA : 8'h55;
            pixel_queue.push_back({c, (k == 0)});
        end
        queue_frame(8, 1'b0, 0);
        queue_frame(4, 1'b1, 0);

        // Scale zero behaves as two; the odd column and row are skipped.
        set_geometry(5, 3, 0);
        queue_frame(15, 1'b1, 0);

        // Scale one behaves as two as well.
        set_geometry(2, 2, 1);
        queue_frame(4, 1'b1, 0);

        // Zero height clips to one; no pooled output can ever form.
        set_geometry(1, 0, 2);
        queue_frame(6, 1'b1, 0);

        // Oversized width and height clip to the source limit; largest scale.
        set_geometry(8191, 8191, 255);
        queue_frame(20, 1'b1, 0);

        random_pixels = 0;
        random_phases_until(70);

        // Second stretch: the idling swaps sides.
        drain_block();
        send_idle_pct = 67;
        recv_idle_pct = 24;

        // Height changed mid-frame: the raster position carries over and
        // wraps at the new bound. Width and scale stay, so every bin read
        // afterwards was written in the same block row.
        set_geometry(6, 6, 3);
        queue_frame(24, 1'b1, 0);
        drain_block();
        write_reg(mpd_pkg::CFG_SOURCE_HEIGHT, 4);
        queue_frame(36, 1'b0, 0);

        random_phases_until(200);

        // Last stretch: no idling on either side.
        drain_block();
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // Another long receiver hold-off, this time at full input rate.
        set_geometry(16, 8, 2);
        hold_requests++;
        queue_frame(128, 1'b1, 0);

        random_phases_until(400);

        drain_block();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (pooled_expected.size() != 0) begin
            report_mismatch($sformatf("%0d pooled pixels never arrived",
                                      pooled_expected.size()));
        end
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
